// ----- src/mrlp_pkg.sv -----
`timescale 1ns / 1ps
package mrlp_pkg;

    localparam logic [3:0] CODE_NONE    = 4'd0;
    localparam logic [3:0] CODE_OK      = 4'd1;
    localparam logic [3:0] CODE_CONNECT = 4'd2;
    localparam logic [3:0] CODE_RING    = 4'd3;
    localparam logic [3:0] CODE_NOCAR   = 4'd4;
    localparam logic [3:0] CODE_ERROR   = 4'd5;
    localparam logic [3:0] CODE_NODT    = 4'd6;
    localparam logic [3:0] CODE_BUSY    = 4'd7;
    localparam logic [3:0] CODE_NOANS   = 4'd8;
    localparam logic [3:0] CODE_RINGING = 4'd9;
    localparam logic [3:0] CODE_VOICE   = 4'd10;
    localparam logic [3:0] CODE_FAX     = 4'd11;
    localparam logic [3:0] CODE_TIMEOUT = 4'd12;

    localparam logic [0:0] CFG_REPORT = 1'd0;
    localparam logic [0:0] CFG_SPEED  = 1'd1;

    localparam int NUM_WORDS = 13;
    localparam int WORD_LEN  = 12;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_MATCH,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       start;
        logic       full;
        logic       timeout;
    } ctl_t;

    function automatic logic [7:0] word_char(input logic [3:0] w, input logic [3:0] i);
        logic [8*WORD_LEN-1:0] s;
        begin
            case (w)
                4'd0:  s = {"AT", 80'h0};
                4'd1:  s = {"OK", 80'h0};
                4'd2:  s = {"CONNECT FAX", 8'h0};
                4'd3:  s = {"CONNECT", 40'h0};
                4'd4:  s = {"RING", 64'h0};
                4'd5:  s = {"NO CARRIER", 16'h0};
                4'd6:  s = {"ERROR", 56'h0};
                4'd7:  s = {"NO DIALTONE", 8'h0};
                4'd8:  s = "NO DIAL TONE";
                4'd9:  s = {"BUSY", 64'h0};
                4'd10: s = {"NO ANSWER", 24'h0};
                4'd11: s = {"RINGING", 40'h0};
                4'd12: s = {"VOICE", 56'h0};
                default: s = '0;
            endcase
            word_char = s[8*WORD_LEN-1-8*i -: 8];
        end
    endfunction

    function automatic logic [3:0] word_len(input logic [3:0] w);
        case (w)
            4'd0, 4'd1: word_len = 4'd2;
            4'd2, 4'd7: word_len = 4'd11;
            4'd3, 4'd11: word_len = 4'd7;
            4'd4, 4'd9: word_len = 4'd4;
            4'd5: word_len = 4'd10;
            4'd6, 4'd12: word_len = 4'd5;
            4'd8: word_len = 4'd12;
            4'd10: word_len = 4'd9;
            default: word_len = 4'd0;
        endcase
    endfunction

endpackage

// ----- src/modem_response_line_parser_top.sv -----
`timescale 1ns / 1ps
// Modem result line parser. Bytes are taken one per cycle while a line is
// collected; each data byte other than a line end is written into the line
// memory. When a line ends, the classifier walks the stored line through the
// registered read port of that memory: first the word compare, then, for a
// CONNECT line with a speed, one byte per cycle for leading blanks and sign
// and a digit step and a multiply step per speed digit; no byte is taken
// meanwhile. A timeout item goes straight into the output register. The
// result waits there, and no item is taken until it has been accepted.
module modem_response_line_parser_top #(
    parameter int LINE_MAX = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // code, speed, line_length, line_full, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import mrlp_pkg::*;

    localparam int CAP = LINE_MAX - 1;
    localparam int AW = $clog2(CAP);
    localparam int CW = $clog2(LINE_MAX) + 1;

    logic [CW-1:0] count_reg, count_next;
    logic report_reg;
    logic [31:0] dspeed_reg;
    logic full_reg;
    logic ov_reg;
    logic [47:0] od_reg;
    logic acc, is_eol, we;
    logic [AW-1:0] raddr;
    logic [7:0] rdata;
    logic busy, done;
    logic [3:0] code;
    logic [31:0] speed;
    ctl_t ctl;

    assign s_tready = !busy && !ov_reg;
    assign cfg_ready = 1'b1;
    assign acc = s_tvalid && s_tready;
    assign is_eol = s_tdata == 8'h0D || s_tdata == 8'h0A;
    assign we = acc && !s_tuser && !is_eol && count_reg < CW'(CAP);
    assign count_next = count_reg + CW'(we);

    always_comb
    begin
        ctl.timeout = acc && s_tuser;
        ctl.full = acc && !s_tuser && !is_eol && count_next >= CW'(CAP);
        ctl.start = (acc && !s_tuser && is_eol && count_reg != '0) || ctl.full;
    end

    mrlp_line_ram #(.DEPTH(CAP), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(s_tdata),
        .raddr(raddr), .rdata(rdata)
    );

    mrlp_classifier #(.CW(CW), .AW(AW)) u_cls (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .count(count_reg),
        .dflt_speed(dspeed_reg), .rdata(rdata), .raddr(raddr), .busy(busy),
        .done(done), .code(code), .speed(speed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            report_reg <= 1'b0;
            dspeed_reg <= 32'd300;
            ov_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_REPORT: report_reg <= cfg_data[0];
                    CFG_SPEED: dspeed_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) ov_reg <= 1'b0;
            if (ctl.timeout)
            begin
                count_reg <= '0;
                ov_reg <= 1'b1;
            end
            else if (done)
            begin
                count_reg <= '0;
                if (code != CODE_NONE || report_reg) ov_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_next;
            end
            if (ctl.start) full_reg <= ctl.full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.timeout)
            od_reg <= {4'd0, 1'b0, 7'd0, 32'd0, CODE_TIMEOUT};
        else if (done)
            od_reg <= {4'd0, full_reg, 7'(count_reg), speed, code};
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;

    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !acc)
        else $error("item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n) we |-> count_reg < CW'(CAP))
        else $error("line overflow");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> count_reg == '0)
        else $error("count not cleared");
endmodule

// ----- src/mrlp_line_ram.sv -----
`timescale 1ns / 1ps
module mrlp_line_ram #(
    parameter int DEPTH = 127,
    parameter int AW = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/mrlp_classifier.sv -----
`timescale 1ns / 1ps
module mrlp_classifier #(
    parameter int CW = 8,
    parameter int AW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mrlp_pkg::ctl_t ctl,
    input  logic [CW-1:0] count,
    input  logic [31:0]   dflt_speed,
    input  logic [7:0]    rdata,
    output logic [AW-1:0] raddr,
    output logic          busy,
    output logic          done,
    output logic [3:0]    code,
    output logic [31:0]   speed
);
    import mrlp_pkg::*;

    state_t state_reg, state_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [NUM_WORDS-1:0] ok_reg, ok_next;
    logic [31:0] val_reg, val_next;
    logic [35:0] prod_reg, prod_next;
    logic neg_reg, neg_next;
    logic sp_reg, sp_next;
    logic pend_reg, pend_next;
    logic [3:0] code_reg, code_next;
    logic [31:0] speed_reg, speed_next;
    logic [3:0] dig;
    logic is_digit, is_ws;
    logic [3:0] pick;
    logic [CW-1:0] pos_plus;
    logic match_end;
    logic go_speed;

    assign dig = 4'(rdata - 8'h30);
    assign is_digit = rdata >= 8'h30 && rdata <= 8'h39;
    assign is_ws = rdata == 8'h20 || rdata == 8'h09 || rdata == 8'h0B || rdata == 8'h0C;
    assign pos_plus = pos_reg + 1'b1;
    assign match_end = pend_reg && (pos_reg > CW'(12) || pos_reg > count);
    assign go_speed = pick == CODE_CONNECT && count > CW'(7) && sp_reg;

    always_comb
    begin
        pick = CODE_NONE;
        if (ok_reg[0] && count >= CW'(2)) pick = CODE_NONE;
        else if (ok_reg[1] && count == CW'(2)) pick = CODE_OK;
        else if (ok_reg[2] && count >= CW'(11)) pick = CODE_FAX;
        else if (ok_reg[3] && count >= CW'(7)) pick = CODE_CONNECT;
        else if (ok_reg[4] && count == CW'(4)) pick = CODE_RING;
        else if (ok_reg[5] && count == CW'(10)) pick = CODE_NOCAR;
        else if (ok_reg[6] && count == CW'(5)) pick = CODE_ERROR;
        else if ((ok_reg[7] && count == CW'(11)) || (ok_reg[8] && count == CW'(12)))
            pick = CODE_NODT;
        else if (ok_reg[9] && count == CW'(4)) pick = CODE_BUSY;
        else if (ok_reg[10] && count == CW'(9)) pick = CODE_NOANS;
        else if (ok_reg[11] && count == CW'(7)) pick = CODE_RINGING;
        else if (ok_reg[12] && count == CW'(5)) pick = CODE_VOICE;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: if (ctl.start) state_next = ST_MATCH;
            ST_MATCH:
                if (match_end)
                begin
                    if (go_speed) state_next = ST_SKIP;
                    else state_next = ST_DONE;
                end
            ST_SKIP: if (pend_reg && (pos_reg >= count || !is_ws)) state_next = ST_SIGN;
            ST_SIGN: if (pend_reg) state_next = ST_DIGIT;
            ST_DIGIT:
                if (pend_reg)
                begin
                    if (pos_reg >= count || !is_digit) state_next = ST_DONE;
                    else state_next = ST_MUL;
                end
            ST_MUL: state_next = ST_DIGIT;
            ST_DONE: state_next = ST_COLLECT;
            default: state_next = ST_COLLECT;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        ok_next = ok_reg;
        val_next = val_reg;
        prod_next = prod_reg;
        neg_next = neg_reg;
        sp_next = sp_reg;
        pend_next = 1'b0;
        code_next = code_reg;
        speed_next = speed_reg;
        raddr = pos_reg[AW-1:0];
        unique case (state_reg)
            ST_COLLECT:
            begin
                pos_next = '0;
                ok_next = '1;
                val_next = '0;
                neg_next = 1'b0;
                sp_next = 1'b0;
                if (ctl.start) pend_next = 1'b1;
            end
            ST_MATCH:
            begin
                if (pend_reg && pos_reg < count && pos_reg < CW'(WORD_LEN))
                begin
                    for (int w = 0; w < NUM_WORDS; w++)
                    begin
                        if (4'(pos_reg) < word_len(4'(w)) &&
                            word_char(4'(w), 4'(pos_reg)) != rdata)
                            ok_next[w] = 1'b0;
                    end
                    if (pos_reg == CW'(7)) sp_next = rdata == 8'h20;
                end
                if (match_end)
                begin
                    code_next = pick;
                    speed_next = '0;
                    if (pick == CODE_CONNECT) speed_next = dflt_speed;
                    pos_next = CW'(8);
                    raddr = AW'(8);
                end
                else
                begin
                    pos_next = pos_plus;
                    raddr = pos_plus[AW-1:0];
                end
                pend_next = 1'b1;
            end
            ST_SKIP:
            begin
                pend_next = 1'b1;
                if (pend_reg && pos_reg < count && is_ws)
                begin
                    pos_next = pos_plus;
                    raddr = pos_plus[AW-1:0];
                end
            end
            ST_SIGN:
            begin
                pend_next = 1'b1;
                if (pend_reg && pos_reg < count && (rdata == 8'h2B || rdata == 8'h2D))
                begin
                    neg_next = rdata == 8'h2D;
                    pos_next = pos_plus;
                    raddr = pos_plus[AW-1:0];
                end
            end
            ST_DIGIT:
            begin
                if (pend_reg && (pos_reg >= count || !is_digit))
                begin
                    speed_next = neg_reg ? 32'd0 : val_reg;
                    pend_next = 1'b0;
                end
                else if (pend_reg)
                begin
                    prod_next = 36'(val_reg) * 36'd10 + 36'(dig);
                end
            end
            ST_MUL:
            begin
                val_next = (prod_reg > 36'hFFFFFFFF) ? 32'hFFFFFFFF : prod_reg[31:0];
                pos_next = pos_plus;
                raddr = pos_plus[AW-1:0];
                pend_next = 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ok_reg <= ok_next;
        val_reg <= val_next;
        prod_reg <= prod_next;
        neg_reg <= neg_next;
        sp_reg <= sp_next;
        code_reg <= code_next;
        speed_reg <= speed_next;
    end

    assign busy = state_reg != ST_COLLECT;
    assign done = state_reg == ST_DONE;
    assign code = code_reg;
    assign speed = speed_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> $past(state_reg) == ST_DIGIT)
        else $error("mul without digit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && !busy) |=> state_reg == ST_MATCH)
        else $error("start lost");
endmodule

// ----- verif/modem_response_line_parser_top_test.sv -----
`timescale 1ns / 1ps
module modem_response_line_parser_top_test;
    import mrlp_pkg::*;

    localparam int LINE_CAP = 127;

    typedef struct {
        logic [3:0]  code;
        logic [31:0] speed;
        logic [6:0]  len;
        logic        full;
    } line_result_t;

    class line_scoreboard;
        logic [7:0]   line_bytes [LINE_CAP];
        int           line_cnt;
        bit           report_unknown;
        logic [31:0]  plain_speed;
        line_result_t pending_q [$];
        int           errors;

        function new();
            line_cnt = 0;
            report_unknown = 0;
            plain_speed = 32'd300;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_reg(logic [0:0] idx, logic [31:0] value);
            if (idx == CFG_REPORT)
                report_unknown = value[0];
            else
                plain_speed = value;
        endfunction

        function bit has_prefix(string w);
            if (line_cnt < w.len())
                return 0;
            for (int i = 0; i < w.len(); i++)
                if (line_bytes[i] != w[i])
                    return 0;
            return 1;
        endfunction

        function bit is_word(string w);
            return line_cnt == w.len() && has_prefix(w);
        endfunction

        function logic [31:0] speed_text(int p);
            logic [63:0] v;
            bit neg;
            v = 0;
            neg = 0;
            while (p < line_cnt && (line_bytes[p] == 8'h20 || line_bytes[p] == 8'h09 ||
                   line_bytes[p] == 8'h0B || line_bytes[p] == 8'h0C))
                p++;
            if (p < line_cnt && (line_bytes[p] == "+" || line_bytes[p] == "-"))
            begin
                neg = line_bytes[p] == "-";
                p++;
            end
            while (p < line_cnt && line_bytes[p] >= "0" && line_bytes[p] <= "9")
            begin
                v = v * 10 + (line_bytes[p] - "0");
                if (v > 64'hFFFF_FFFF)
                    v = 64'hFFFF_FFFF;
                p++;
            end
            return neg ? 32'd0 : v[31:0];
        endfunction

        function void classify_line(bit full);
            line_result_t r;
            r.speed = 0;
            r.full = full;
            r.len = line_cnt[6:0];
            if (has_prefix("AT")) r.code = CODE_NONE;
            else if (is_word("OK")) r.code = CODE_OK;
            else if (has_prefix("CONNECT FAX")) r.code = CODE_FAX;
            else if (has_prefix("CONNECT"))
            begin
                r.code = CODE_CONNECT;
                if (line_cnt > 7 && line_bytes[7] == 8'h20)
                    r.speed = speed_text(8);
                else
                    r.speed = plain_speed;
            end
            else if (is_word("RING")) r.code = CODE_RING;
            else if (is_word("NO CARRIER")) r.code = CODE_NOCAR;
            else if (is_word("ERROR")) r.code = CODE_ERROR;
            else if (is_word("NO DIALTONE") || is_word("NO DIAL TONE")) r.code = CODE_NODT;
            else if (is_word("BUSY")) r.code = CODE_BUSY;
            else if (is_word("NO ANSWER")) r.code = CODE_NOANS;
            else if (is_word("RINGING")) r.code = CODE_RINGING;
            else if (is_word("VOICE")) r.code = CODE_VOICE;
            else r.code = CODE_NONE;
            line_cnt = 0;
            if (r.code != CODE_NONE || report_unknown)
                pending_q.push_back(r);
        endfunction

        function void note_item(bit kind, logic [7:0] b);
            line_result_t r;
            if (kind)
            begin
                line_cnt = 0;
                r.code = CODE_TIMEOUT;
                r.speed = 0;
                r.len = 0;
                r.full = 0;
                pending_q.push_back(r);
            end
            else if (b == 8'h0D || b == 8'h0A)
            begin
                if (line_cnt != 0)
                    classify_line(0);
            end
            else
            begin
                line_bytes[line_cnt] = b;
                line_cnt++;
                if (line_cnt >= LINE_CAP)
                    classify_line(1);
            end
        endfunction

        task check_result(logic [47:0] d);
            line_result_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", d));
                return;
            end
            e = pending_q.pop_front();
            if (d[3:0] !== e.code)
                report($sformatf("code %0d, want %0d", d[3:0], e.code));
            if (d[35:4] !== e.speed)
                report($sformatf("speed %0d, want %0d", d[35:4], e.speed));
            if (d[42:36] !== e.len)
                report($sformatf("length %0d, want %0d", d[42:36], e.len));
            if (d[43] !== e.full)
                report($sformatf("full %0b, want %0b", d[43], e.full));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    line_scoreboard sb;
    int  items_sent;
    bit  idle_on;
    bit  hold_long;
    int  rx_idle;

    string words [12] = '{"OK", "CONNECT", "CONNECT FAX", "RING", "NO CARRIER", "ERROR",
                          "NO DIALTONE", "NO DIAL TONE", "BUSY", "NO ANSWER", "RINGING",
                          "VOICE"};

    modem_response_line_parser_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_long)
            m_tready <= 0;
        else if (rx_idle > 0)
        begin
            rx_idle--;
            m_tready <= 0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            rx_idle = $urandom_range(1, 12) - 1;
            m_tready <= 0;
        end
        else
            m_tready <= 1;
    end

    always @(negedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // long receiver stall while the sender keeps offering
    initial
    begin
        hold_long = 0;
        wait (items_sent >= 250);
        @(posedge clk);
        hold_long <= 1;
        repeat (2000) @(posedge clk);
        hold_long <= 0;
    end

    initial
    begin
        #10000000;
        $display("modem_response_line_parser_top_test failed");
        $finish;
    end

    task send_item(bit kind, logic [7:0] b);
        bit ok;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= b;
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end while (!ok);
        sb.note_item(kind, b);
        items_sent++;
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(0, s[i]);
    endtask

    task send_junk(int n, bit no_eol);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (no_eol && (b == 8'h0D || b == 8'h0A))
                b = 8'h00;
            send_item(0, b);
        end
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task write_reg(logic [0:0] idx, logic [31:0] value);
        bit ok;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end while (!ok);
        cfg_valid <= 0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task random_line();
        int r;
        string s;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            s = words[$urandom_range(0, 11)];
            if (s == "CONNECT" && $urandom_range(0, 2) != 0)
            begin
                s = {s, " "};
                repeat ($urandom_range(0, 2))
                    s = {s, string'(8'($urandom_range(0, 1) ? 8'h20 : 8'h09))};
                case ($urandom_range(0, 3))
                    0: s = {s, "+"};
                    1: s = {s, "-"};
                    default: ;
                endcase
                repeat ($urandom_range(0, 12)) s = {s, string'(8'($urandom_range(48, 57)))};
                if ($urandom_range(0, 3) == 0) s = {s, "x9"};
            end
            if ($urandom_range(0, 5) == 0)
                s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(32, 126));
            send_text(s);
            send_item(0, $urandom_range(0, 1) ? 8'h0D : 8'h0A);
            if ($urandom_range(0, 1)) send_item(0, 8'h0A);
        end
        else if (r < 62)
        begin
            send_text("AT");
            repeat ($urandom_range(0, 10)) send_item(0, 8'($urandom_range(32, 126)));
            send_item(0, 8'h0D);
        end
        else if (r < 80)
        begin
            send_junk($urandom_range(1, 20), 0);
            send_item(0, 8'h0D);
        end
        else if (r < 90)
        begin
            send_junk($urandom_range(0, 6), 0);
            send_item(1, 8'($urandom_range(0, 255)));
        end
        else if (r < 92)
            send_junk(LINE_CAP, 1);
        else
            repeat ($urandom_range(1, 3)) send_item(0, $urandom_range(0, 1) ? 8'h0D : 8'h0A);
    endtask

    initial
    begin
        sb = new();
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = CFG_REPORT;
        cfg_data = 0;
        items_sent = 0;
        idle_on = 1;
        rx_idle = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset settings first: unknown lines silent, default speed 300
        send_text("\r\nOK\r");
        send_text("CONNECT\r");
        send_text("CONNECT 115200\r");
        send_text("CONNECT \t\v\f-57600\n");
        send_text("CONNECT +99999999999\r");
        send_text("CONNECTX\r");
        send_text("CONNECT FAX\r");
        send_text("RING\nNO CARRIER\rERROR\rNO DIALTONE\rNO DIAL TONE\r");
        send_text("BUSY\rNO ANSWER\rRINGING\rVOICE\r");
        send_text("ATDT5551234\rOKAY\r");
        send_text("RI");
        send_item(1, 8'hFF);
        send_item(0, 8'h00);
        send_item(0, 8'hFF);
        send_junk(LINE_CAP - 2, 1);
        drain();

        write_reg(CFG_REPORT, 32'd1);
        write_reg(CFG_SPEED, 32'd0);
        send_text("ATZ\rHELLO\rCONNECT\rCONNECT 4294967295\rCONNECT 4294967296\r");
        send_item(0, 8'h00);
        send_item(0, 8'h0D);
        drain();

        write_reg(CFG_SPEED, 32'hFFFF_FFFF);
        while (items_sent < 1400)
        begin
            random_line();
            if (items_sent > 1200)
                idle_on = 0;
            if (items_sent > 700 && sb.report_unknown && sb.plain_speed == 32'hFFFF_FFFF)
            begin
                drain();
                write_reg(CFG_REPORT, 32'd0);
                write_reg(CFG_SPEED, $urandom);
            end
            else if (items_sent > 1000 && !sb.report_unknown)
            begin
                drain();
                write_reg(CFG_REPORT, 32'd1);
                write_reg(CFG_SPEED, 32'd300);
            end
        end
        drain();

        if (sb.errors == 0)
            $display("modem_response_line_parser_top_test passed");
        else
            $display("modem_response_line_parser_top_test failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/mrlp_pkg.sv
src/mrlp_line_ram.sv
src/mrlp_classifier.sv
src/modem_response_line_parser_top.sv
verif/modem_response_line_parser_top_test.sv
